[rtl/core/prd_pkg.sv]
// shared types, widths and constants of the panoramic ray direction block
package prd_pkg;

    localparam int COORD_W = 32;
    localparam int RES_W = 13;
    localparam int PS_W = 32;
    localparam int LIM_W = 16;
    localparam int VLIM_W = 15;
    localparam int BASIS_W = 48;
    localparam int COMP_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W = COORD_W + LIM_W;
    localparam int NUM_W = PROD_W + 9;
    localparam int DEN_W = PS_W + RES_W;
    localparam int MOD_W = 25;
    localparam int ANG_W = 32;
    localparam int CW = 34;
    localparam int TRIG_W = 32;
    localparam int COEF_W = 33;
    localparam int TERM_W = COEF_W + COMP_W;
    localparam int ACC_W = TERM_W + 2;

    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN = 24;
    localparam int MAX_RESOLUTION = 4096;

    localparam logic [MOD_W-1:0] DEG360_Q16 = 25'd23592960;
    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    localparam logic [RES_W-1:0] HRES_RESET = 13'd640;
    localparam logic [RES_W-1:0] VRES_RESET = 13'd480;
    localparam logic [PS_W-1:0] PSIZE_RESET = 32'd65536;
    localparam logic [LIM_W-1:0] HLIM_RESET = 16'd46080;
    localparam logic [VLIM_W-1:0] VLIM_RESET = 15'd23040;
    localparam logic [BASIS_W-1:0] RIGHT_RESET = 48'h0000_0000_4000;
    localparam logic [BASIS_W-1:0] UP_RESET = 48'h0000_4000_0000;
    localparam logic [BASIS_W-1:0] BACK_RESET = 48'h4000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HRES,
        REG_VRES,
        REG_PSIZE,
        REG_HLIM,
        REG_VLIM,
        REG_RIGHT,
        REG_UP,
        REG_BACK
    } cfg_reg_t;

    typedef struct packed {
        logic valid;
        logic neg;
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic [MOD_W-1:0] qm;
    } div_t;

    typedef struct packed {
        logic valid;
        logic [MOD_W-1:0] r;
        logic [ANG_W-1:0] b;
    } turn_t;

    typedef struct packed {
        logic valid;
        logic flip;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic valid;
        logic signed [TRIG_W-1:0] s;
        logic signed [TRIG_W-1:0] c;
    } trig_t;

    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0: v = 32'd843314857;
            1: v = 32'd497837829;
            2: v = 32'd263043837;
            3: v = 32'd133525159;
            4: v = 32'd67021687;
            5: v = 32'd33543516;
            6: v = 32'd16775851;
            7: v = 32'd8388437;
            8: v = 32'd4194283;
            9: v = 32'd2097149;
            10: v = 32'd1048576;
            11: v = 32'd524288;
            12: v = 32'd262144;
            13: v = 32'd131072;
            14: v = 32'd65536;
            15: v = 32'd32768;
            16: v = 32'd16384;
            17: v = 32'd8192;
            18: v = 32'd4096;
            19: v = 32'd2048;
            20: v = 32'd1024;
            21: v = 32'd512;
            22: v = 32'd256;
            23: v = 32'd128;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/prd_div_cell.sv]
// one restoring divide step that also keeps the quotient modulo a full turn
module prd_div_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic [prd_pkg::DEN_W-1:0]   den,
    input  prd_pkg::div_t               in_st,
    output prd_pkg::div_t               out_st
);

    localparam int DW = prd_pkg::DEN_W;
    localparam int NW = prd_pkg::NUM_W;
    localparam int MW = prd_pkg::MOD_W;

    prd_pkg::div_t st_reg;
    prd_pkg::div_t st_next;

    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;
    logic [MW:0] qm2;
    logic [MW:0] qm_diff;
    logic        qm_ge;

    assign trial = {in_st.rem, in_st.num[NW-1]};
    assign diff = trial - {1'b0, den};
    assign ge = trial >= {1'b0, den};
    assign qm2 = {in_st.qm, ge};
    assign qm_diff = qm2 - {1'b0, prd_pkg::DEG360_Q16};
    assign qm_ge = qm2 >= {1'b0, prd_pkg::DEG360_Q16};

    always_comb begin
        st_next.valid = in_st.valid;
        st_next.neg = in_st.neg;
        st_next.rem = ge ? diff[DW-1:0] : trial[DW-1:0];
        st_next.num = {in_st.num[NW-2:0], 1'b0};
        st_next.qm = qm_ge ? qm_diff[MW-1:0] : qm2[MW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.valid <= 1'b0;
        end else if (en) begin
            st_reg <= st_next;
        end
    end

    assign out_st = st_reg;

endmodule

[rtl/core/prd_cordic_cell.sv]
// one rotation-mode cordic iteration with a fixed shift
module prd_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  prd_pkg::cordic_t   in_st,
    output prd_pkg::cordic_t   out_st
);

    localparam int CW = prd_pkg::CW;
    localparam logic signed [CW-1:0] ATAN = CW'(prd_pkg::atan_q30(SHIFT));

    prd_pkg::cordic_t st_reg;
    prd_pkg::cordic_t st_next;

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    assign xs = in_st.x >>> SHIFT;
    assign ys = in_st.y >>> SHIFT;

    always_comb begin
        st_next.valid = in_st.valid;
        st_next.flip = in_st.flip;
        if (!in_st.z[CW-1]) begin
            st_next.x = in_st.x - ys;
            st_next.y = in_st.y + xs;
            st_next.z = in_st.z - ATAN;
        end else begin
            st_next.x = in_st.x + ys;
            st_next.y = in_st.y - xs;
            st_next.z = in_st.z + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.valid <= 1'b0;
        end else if (en) begin
            st_reg <= st_next;
        end
    end

    assign out_st = st_reg;

endmodule

[rtl/core/prd_lane.sv]
// one angle lane: scaling, divider chain, turn scaling chain and cordic chain
module prd_lane #(
    parameter int CORDIC_STEPS = prd_pkg::CORDIC_STEPS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [prd_pkg::COORD_W-1:0] coord,
    input  logic [prd_pkg::LIM_W-1:0]     limit,
    input  logic [prd_pkg::DEN_W-1:0]     den,
    output prd_pkg::trig_t                trig
);

    localparam int CO_W = prd_pkg::COORD_W;
    localparam int PW = prd_pkg::PROD_W;
    localparam int NW = prd_pkg::NUM_W;
    localparam int MW = prd_pkg::MOD_W;
    localparam int AW = prd_pkg::ANG_W;
    localparam int CW = prd_pkg::CW;
    localparam int TW = prd_pkg::TRIG_W;
    localparam int STEPS = (CORDIC_STEPS > prd_pkg::TABLE_LEN) ?
                           prd_pkg::TABLE_LEN : CORDIC_STEPS;

    // magnitude and scaling
    logic [CO_W-1:0] coord_u;
    logic [CO_W-1:0] mag_next;
    logic            l0_valid_reg;
    logic            l0_neg_reg;
    logic [CO_W-1:0] l0_mag_reg;
    logic            l1_valid_reg;
    logic            l1_neg_reg;
    logic [PW-1:0]   l1_prod_reg;

    assign coord_u = coord;
    assign mag_next = coord_u[CO_W-1] ? (~coord_u + CO_W'(1)) : coord_u;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l0_valid_reg <= 1'b0;
            l1_valid_reg <= 1'b0;
        end else if (en) begin
            l0_valid_reg <= in_valid;
            l0_neg_reg <= coord_u[CO_W-1];
            l0_mag_reg <= mag_next;
            l1_valid_reg <= l0_valid_reg;
            l1_neg_reg <= l0_neg_reg;
            l1_prod_reg <= PW'(l0_mag_reg) * PW'(limit);
        end
    end

    // divider chain
    prd_pkg::div_t div_st [NW+1];

    assign div_st[0] = '{valid: l1_valid_reg, neg: l1_neg_reg, rem: '0,
                         num: {l1_prod_reg, {(NW-PW){1'b0}}}, qm: '0};

    for (genvar i = 0; i < NW; i++) begin : g_div
        prd_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .den     (den),
            .in_st   (div_st[i]),
            .out_st  (div_st[i+1])
        );
    end

    // sign fold into [0, 360)
    prd_pkg::div_t div_last;
    logic [MW-1:0] fold_next;
    prd_pkg::turn_t fold_reg;

    assign div_last = div_st[NW];

    always_comb begin
        if (den == '0) begin
            fold_next = '0;
        end else if (div_last.neg && (div_last.qm != '0)) begin
            fold_next = prd_pkg::DEG360_Q16 - div_last.qm;
        end else begin
            fold_next = div_last.qm;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_reg.valid <= 1'b0;
        end else if (en) begin
            fold_reg <= '{valid: div_last.valid, r: fold_next, b: '0};
        end
    end

    // binary angle chain, one quotient bit per cell
    prd_pkg::turn_t turn_in [AW];
    prd_pkg::turn_t turn_next [AW];
    prd_pkg::turn_t turn_reg [AW];
    logic [MW:0]    turn_t2 [AW];
    logic [MW:0]    turn_diff [AW];
    logic           turn_ge [AW];

    for (genvar j = 0; j < AW; j++) begin : g_turn
        if (j == 0) begin : g_first
            assign turn_in[j] = fold_reg;
        end else begin : g_rest
            assign turn_in[j] = turn_reg[j-1];
        end
        assign turn_t2[j] = {turn_in[j].r, 1'b0};
        assign turn_diff[j] = turn_t2[j] - {1'b0, prd_pkg::DEG360_Q16};
        assign turn_ge[j] = turn_t2[j] >= {1'b0, prd_pkg::DEG360_Q16};
        assign turn_next[j] = '{valid: turn_in[j].valid,
                                r: turn_ge[j] ? turn_diff[j][MW-1:0] : turn_t2[j][MW-1:0],
                                b: {turn_in[j].b[AW-2:0], turn_ge[j]}};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                turn_reg[j].valid <= 1'b0;
            end else if (en) begin
                turn_reg[j] <= turn_next[j];
            end
        end
    end

    // quadrant fold and conversion to radians
    logic [AW-1:0] bang;
    logic          flip_next;
    logic [AW-1:0] bfold;
    logic [AW-1:0] amag_full;
    logic          r1_valid_reg;
    logic          r1_flip_reg;
    logic          r1_neg_reg;
    logic [AW-2:0] r1_mag_reg;
    logic          r2_valid_reg;
    logic          r2_flip_reg;
    logic          r2_neg_reg;
    logic [2*AW-2:0] r2_prod_reg;

    assign bang = turn_reg[AW-1].b;
    assign flip_next = bang[AW-1] ^ bang[AW-2];
    assign bfold = {bang[AW-1] ^ flip_next, bang[AW-2:0]};
    assign amag_full = bfold[AW-1] ? (~bfold + AW'(1)) : bfold;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r1_valid_reg <= 1'b0;
            r2_valid_reg <= 1'b0;
        end else if (en) begin
            r1_valid_reg <= turn_reg[AW-1].valid;
            r1_flip_reg <= flip_next;
            r1_neg_reg <= bfold[AW-1];
            r1_mag_reg <= amag_full[AW-2:0];
            r2_valid_reg <= r1_valid_reg;
            r2_flip_reg <= r1_flip_reg;
            r2_neg_reg <= r1_neg_reg;
            r2_prod_reg <= (2*AW-1)'(r1_mag_reg) * (2*AW-1)'(prd_pkg::PI_Q30);
        end
    end

    // cordic chain
    logic [CW-1:0] zmag;
    logic [CW-1:0] z0;
    prd_pkg::cordic_t cor_st [STEPS+1];

    assign zmag = CW'(r2_prod_reg[2*AW-2:AW-1]);
    assign z0 = r2_neg_reg ? (~zmag + CW'(1)) : zmag;
    assign cor_st[0] = '{valid: r2_valid_reg, flip: r2_flip_reg,
                         x: prd_pkg::CORDIC_GAIN_Q30, y: '0, z: z0};

    for (genvar k = 0; k < STEPS; k++) begin : g_cordic
        prd_cordic_cell #(
            .SHIFT (k)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in_st   (cor_st[k]),
            .out_st  (cor_st[k+1])
        );
    end

    // undo the half turn fold
    prd_pkg::cordic_t cor_last;
    logic signed [CW-1:0] s_full;
    logic signed [CW-1:0] c_full;
    prd_pkg::trig_t trig_reg;

    assign cor_last = cor_st[STEPS];
    assign s_full = cor_last.flip ? -cor_last.y : cor_last.y;
    assign c_full = cor_last.flip ? -cor_last.x : cor_last.x;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_reg.valid <= 1'b0;
        end else if (en) begin
            trig_reg.valid <= cor_last.valid;
            trig_reg.s <= s_full[TW-1:0];
            trig_reg.c <= c_full[TW-1:0];
        end
    end

    assign trig = trig_reg;

endmodule

[rtl/core/prd_combine.sv]
// coefficient products, basis weighting, rounding and saturation
module prd_combine (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  prd_pkg::trig_t                 lon,
    input  prd_pkg::trig_t                 lat,
    input  logic [prd_pkg::BASIS_W-1:0]    basis_right,
    input  logic [prd_pkg::BASIS_W-1:0]    basis_up,
    input  logic [prd_pkg::BASIS_W-1:0]    basis_back,
    output logic                           out_valid,
    output logic signed [prd_pkg::COMP_W-1:0] dir_x,
    output logic signed [prd_pkg::COMP_W-1:0] dir_y,
    output logic signed [prd_pkg::COMP_W-1:0] dir_z
);

    localparam int TW = prd_pkg::TRIG_W;
    localparam int KW = prd_pkg::COEF_W;
    localparam int QW = prd_pkg::COMP_W;
    localparam int PW = prd_pkg::TERM_W;
    localparam int AW = prd_pkg::ACC_W;
    localparam int MW = 2 * TW;
    localparam logic signed [MW-1:0] HALF_M = MW'(64'sd536870912);
    localparam logic signed [AW-1:0] HALF_A = AW'(64'sd536870912);
    localparam int RW = AW - 30;
    localparam logic signed [RW-1:0] SAT_HI = RW'(32767);
    localparam logic signed [RW-1:0] SAT_LO = RW'(-32768);

    // products of the trig terms
    logic                  c2_valid_reg;
    logic signed [MW-1:0]  pa_reg;
    logic signed [MW-1:0]  pb_reg;
    logic signed [TW-1:0]  sp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c2_valid_reg <= 1'b0;
        end else if (en) begin
            c2_valid_reg <= lon.valid & lat.valid;
            pa_reg <= lon.s * lat.c;
            pb_reg <= lon.c * lat.c;
            sp_reg <= lat.s;
        end
    end

    // round to q30 coefficients
    logic signed [MW-1:0] ra;
    logic signed [MW-1:0] rb;
    logic signed [MW-1:0] rb_neg;
    logic                 c3_valid_reg;
    logic signed [KW-1:0] ca_reg;
    logic signed [KW-1:0] cb_reg;
    logic signed [KW-1:0] cc_reg;

    assign ra = (pa_reg + HALF_M) >>> 30;
    assign rb = (pb_reg + HALF_M) >>> 30;
    assign rb_neg = -rb;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c3_valid_reg <= 1'b0;
        end else if (en) begin
            c3_valid_reg <= c2_valid_reg;
            ca_reg <= ra[KW-1:0];
            cb_reg <= {sp_reg[TW-1], sp_reg};
            cc_reg <= rb_neg[KW-1:0];
        end
    end

    // basis products per component
    logic signed [PW-1:0] pu_reg [3];
    logic signed [PW-1:0] pv_reg [3];
    logic signed [PW-1:0] pw_reg [3];
    logic                 c4_valid_reg;
    logic signed [AW-1:0] acc [3];
    logic signed [RW-1:0] rnd [3];
    logic signed [QW-1:0] sat_next [3];
    logic signed [QW-1:0] dir_reg [3];
    logic                 c5_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c4_valid_reg <= 1'b0;
            c5_valid_reg <= 1'b0;
        end else if (en) begin
            c4_valid_reg <= c3_valid_reg;
            c5_valid_reg <= c4_valid_reg;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_comp
        always_ff @(posedge aclk) begin
            if (en) begin
                pu_reg[k] <= ca_reg * $signed(basis_right[QW*k +: QW]);
                pv_reg[k] <= cb_reg * $signed(basis_up[QW*k +: QW]);
                pw_reg[k] <= cc_reg * $signed(basis_back[QW*k +: QW]);
                dir_reg[k] <= sat_next[k];
            end
        end

        assign acc[k] = AW'(pu_reg[k]) + AW'(pv_reg[k]) + AW'(pw_reg[k]) + HALF_A;
        assign rnd[k] = RW'(acc[k] >>> 30);

        always_comb begin
            if (rnd[k] > SAT_HI) begin
                sat_next[k] = QW'(SAT_HI);
            end else if (rnd[k] < SAT_LO) begin
                sat_next[k] = QW'(SAT_LO);
            end else begin
                sat_next[k] = rnd[k][QW-1:0];
            end
        end
    end

    assign out_valid = c5_valid_reg;
    assign dir_x = dir_reg[0];
    assign dir_y = dir_reg[1];
    assign dir_z = dir_reg[2];

endmodule

[rtl/core/panoramic_ray_direction.sv]
// top level of the spherical panoramic camera ray direction block
//
// usage: a view-plane point (s_point_x, s_point_y, signed q16.16) goes in on
// the s_ channel; one ray direction (m_dir_x/y/z, signed q2.14, saturated)
// comes out on the m_ channel for every request, in order.
// the cfg_ channel writes one register per request: index 0 horizontal
// resolution, 1 vertical resolution, 2 pixel size, 3 and 4 the half field
// limits, 5 to 7 the right, up and back basis vectors. cfg_ready is always
// high; write only while no request is in flight.
// the pipeline depth comes mostly from the 57-cell restoring divider chain,
// the 32-cell turn scaling chain and the cordic chain of each angle lane.
// throughput: one request per cycle while the pipeline is not stalled.
// stall: the whole pipeline holds when its last stage is full and the
// output register waits on m_ready; empty slots still move, so s_ready
// stays high while a result waits and the pipeline has a bubble at its end.
// reset: aresetn low clears all valid bits and loads the register defaults
// (640 x 480, pixel size 1.0, 180 and 90 degree limits, identity basis).
module panoramic_ray_direction #(
    parameter int CORDIC_STEPS = prd_pkg::CORDIC_STEPS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [prd_pkg::COORD_W-1:0] s_point_x,
    input  logic signed [prd_pkg::COORD_W-1:0] s_point_y,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [prd_pkg::COMP_W-1:0] m_dir_x,
    output logic signed [prd_pkg::COMP_W-1:0] m_dir_y,
    output logic signed [prd_pkg::COMP_W-1:0] m_dir_z,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [prd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [prd_pkg::BASIS_W-1:0]       cfg_data
);

    localparam int RES_W = prd_pkg::RES_W;
    localparam int PS_W = prd_pkg::PS_W;
    localparam int LIM_W = prd_pkg::LIM_W;
    localparam int VLIM_W = prd_pkg::VLIM_W;
    localparam int BW = prd_pkg::BASIS_W;
    localparam int DW = prd_pkg::DEN_W;
    localparam int QW = prd_pkg::COMP_W;

    // configuration registers
    logic [RES_W-1:0]  hres_reg;
    logic [RES_W-1:0]  vres_reg;
    logic [PS_W-1:0]   psize_reg;
    logic [LIM_W-1:0]  hlim_reg;
    logic [VLIM_W-1:0] vlim_reg;
    logic [BW-1:0]     right_reg;
    logic [BW-1:0]     up_reg;
    logic [BW-1:0]     back_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hres_reg <= prd_pkg::HRES_RESET;
            vres_reg <= prd_pkg::VRES_RESET;
            psize_reg <= prd_pkg::PSIZE_RESET;
            hlim_reg <= prd_pkg::HLIM_RESET;
            vlim_reg <= prd_pkg::VLIM_RESET;
            right_reg <= prd_pkg::RIGHT_RESET;
            up_reg <= prd_pkg::UP_RESET;
            back_reg <= prd_pkg::BACK_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (prd_pkg::cfg_reg_t'(cfg_index))
                prd_pkg::REG_HRES: hres_reg <= cfg_data[RES_W-1:0];
                prd_pkg::REG_VRES: vres_reg <= cfg_data[RES_W-1:0];
                prd_pkg::REG_PSIZE: psize_reg <= cfg_data[PS_W-1:0];
                prd_pkg::REG_HLIM: hlim_reg <= cfg_data[LIM_W-1:0];
                prd_pkg::REG_VLIM: vlim_reg <= cfg_data[VLIM_W-1:0];
                prd_pkg::REG_RIGHT: right_reg <= cfg_data;
                prd_pkg::REG_UP: up_reg <= cfg_data;
                prd_pkg::REG_BACK: back_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // divisors, clamped resolution times pixel size
    logic [RES_W-1:0] hres_c;
    logic [RES_W-1:0] vres_c;
    logic [DW-1:0]    den_h_reg;
    logic [DW-1:0]    den_v_reg;

    assign hres_c = (32'(hres_reg) > prd_pkg::MAX_RESOLUTION) ?
                    RES_W'(prd_pkg::MAX_RESOLUTION) : hres_reg;
    assign vres_c = (32'(vres_reg) > prd_pkg::MAX_RESOLUTION) ?
                    RES_W'(prd_pkg::MAX_RESOLUTION) : vres_reg;

    always_ff @(posedge aclk) begin
        den_h_reg <= DW'(psize_reg) * DW'(hres_c);
        den_v_reg <= DW'(psize_reg) * DW'(vres_c);
    end

    // pipeline advance
    logic           adv;
    logic           last_valid;
    prd_pkg::trig_t lon;
    prd_pkg::trig_t lat;
    logic signed [QW-1:0] dx;
    logic signed [QW-1:0] dy;
    logic signed [QW-1:0] dz;
    logic           m_valid_reg;
    logic signed [QW-1:0] m_dir_x_reg;
    logic signed [QW-1:0] m_dir_y_reg;
    logic signed [QW-1:0] m_dir_z_reg;

    assign adv = !last_valid || !m_valid_reg || m_ready;
    assign s_ready = adv;

    prd_lane #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_lane_h (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (s_valid),
        .coord    (s_point_x),
        .limit    (hlim_reg),
        .den      (den_h_reg),
        .trig     (lon)
    );

    prd_lane #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_lane_v (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (s_valid),
        .coord    (s_point_y),
        .limit    ({1'b0, vlim_reg}),
        .den      (den_v_reg),
        .trig     (lat)
    );

    prd_combine u_combine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (adv),
        .lon         (lon),
        .lat         (lat),
        .basis_right (right_reg),
        .basis_up    (up_reg),
        .basis_back  (back_reg),
        .out_valid   (last_valid),
        .dir_x       (dx),
        .dir_y       (dy),
        .dir_z       (dz)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= (adv && last_valid) || (m_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && last_valid) begin
            m_dir_x_reg <= dx;
            m_dir_y_reg <= dy;
            m_dir_z_reg <= dz;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_dir_x = m_dir_x_reg;
    assign m_dir_y = m_dir_y_reg;
    assign m_dir_z = m_dir_z_reg;

    // checks
    a_ready_only_on_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid_reg && !m_ready && last_valid))
        else $error("input stalled without a full output stall");

    a_stall_keeps_last: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> last_valid)
        else $error("last stage lost its result during a stall");

    a_lanes_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        lon.valid == lat.valid)
        else $error("angle lanes out of step");

    a_clear_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid_reg)
        else $error("output valid after reset");

endmodule

[sim/tb.sv]
// self-checking testbench of the panoramic ray direction block
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W = prd_pkg::COORD_W;
    localparam int RES_W = prd_pkg::RES_W;
    localparam int PS_W = prd_pkg::PS_W;
    localparam int LIM_W = prd_pkg::LIM_W;
    localparam int VLIM_W = prd_pkg::VLIM_W;
    localparam int BASIS_W = prd_pkg::BASIS_W;
    localparam int COMP_W = prd_pkg::COMP_W;
    localparam int CFG_IDX_W = prd_pkg::CFG_IDX_W;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int LATENCY = prd_pkg::CORDIC_STEPS + 99;

    typedef struct {
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
    } ray_t;

    class ray_scoreboard;
        logic [RES_W-1:0] hres;
        logic [RES_W-1:0] vres;
        logic [PS_W-1:0] psize;
        logic [LIM_W-1:0] hlim;
        logic [VLIM_W-1:0] vlim;
        logic [BASIS_W-1:0] right_v;
        logic [BASIS_W-1:0] up_v;
        logic [BASIS_W-1:0] back_v;
        ray_t pending[$];
        int errors;
        int checked;
        longint arctan[24] = '{
            843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
            16775851, 8388437, 4194283, 2097149, 1048576, 524288,
            262144, 131072, 65536, 32768, 16384, 8192,
            4096, 2048, 1024, 512, 256, 128};

        function new();
            hres = prd_pkg::HRES_RESET;
            vres = prd_pkg::VRES_RESET;
            psize = prd_pkg::PSIZE_RESET;
            hlim = prd_pkg::HLIM_RESET;
            vlim = prd_pkg::VLIM_RESET;
            right_v = prd_pkg::RIGHT_RESET;
            up_v = prd_pkg::UP_RESET;
            back_v = prd_pkg::BACK_RESET;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(prd_pkg::cfg_reg_t idx, logic [BASIS_W-1:0] val);
            case (idx)
                prd_pkg::REG_HRES: hres = val[RES_W-1:0];
                prd_pkg::REG_VRES: vres = val[RES_W-1:0];
                prd_pkg::REG_PSIZE: psize = val[PS_W-1:0];
                prd_pkg::REG_HLIM: hlim = val[LIM_W-1:0];
                prd_pkg::REG_VLIM: vlim = val[VLIM_W-1:0];
                prd_pkg::REG_RIGHT: right_v = val;
                prd_pkg::REG_UP: up_v = val;
                prd_pkg::REG_BACK: back_v = val;
                default: ;
            endcase
        endfunction

        // binary angle, full turn = 2^32
        function logic [31:0] turn_angle(longint coord, longint unsigned lim,
                                         longint unsigned res);
            longint unsigned den, mag, q;
            if (res > 4096)
                res = 4096;
            den = longint'(psize) * res;
            if (den == 0)
                return 0;
            mag = coord < 0 ? -coord : coord;
            q = (mag * 2 * lim * 256) / den;
            q = q % 64'd23592960;
            if (coord < 0 && q != 0)
                q = 64'd23592960 - q;
            return 32'((q << 32) / 64'd23592960);
        endfunction

        function void sincos(logic [31:0] b, output longint s, output longint c);
            logic [31:0] probe;
            logic flip;
            longint a, z, x, y, t;
            longint unsigned mag;
            int steps;
            probe = b + 32'h4000_0000;
            flip = probe >= 32'h8000_0000;
            if (flip)
                b = b - 32'h8000_0000;
            a = longint'($signed(b));
            mag = a < 0 ? -a : a;
            mag = (mag * 64'd3373259426) >> 31;
            z = a < 0 ? -longint'(mag) : longint'(mag);
            x = 652032874;
            y = 0;
            steps = prd_pkg::CORDIC_STEPS > 24 ? 24 : prd_pkg::CORDIC_STEPS;
            for (int i = 0; i < steps; i++) begin
                if (z >= 0) begin
                    t = x - (y >>> i);
                    y = y + (x >>> i);
                    z -= arctan[i];
                end else begin
                    t = x + (y >>> i);
                    y = y - (x >>> i);
                    z += arctan[i];
                end
                x = t;
            end
            s = flip ? -y : y;
            c = flip ? -x : x;
        endfunction

        function longint mul30(longint a, longint b);
            return (a * b + (longint'(1) << 29)) >>> 30;
        endfunction

        function void note(logic signed [31:0] px, logic signed [31:0] py);
            longint sl, cl, sp, cp, ca, cc, acc, r;
            logic signed [COMP_W-1:0] d[3];
            ray_t e;
            sincos(turn_angle(longint'(px), hlim, hres), sl, cl);
            sincos(turn_angle(longint'(py), vlim, vres), sp, cp);
            ca = mul30(sl, cp);
            cc = -mul30(cl, cp);
            for (int k = 0; k < 3; k++) begin
                acc = ca * longint'($signed(right_v[16*k +: 16]))
                    + sp * longint'($signed(up_v[16*k +: 16]))
                    + cc * longint'($signed(back_v[16*k +: 16]));
                r = (acc + (longint'(1) << 29)) >>> 30;
                if (r > 32767) r = 32767;
                if (r < -32768) r = -32768;
                d[k] = r[15:0];
            end
            e.x = d[0];
            e.y = d[1];
            e.z = d[2];
            pending.push_back(e);
        endfunction

        task report(string msg);
            $display("error: %s", msg);
            errors++;
        endtask

        task check(logic signed [15:0] x, logic signed [15:0] y,
                   logic signed [15:0] z);
            ray_t e;
            checked++;
            if (pending.size() == 0) begin
                report($sformatf("unexpected ray %0d %0d %0d", x, y, z));
                return;
            end
            e = pending.pop_front();
            if (x !== e.x) report($sformatf("ray %0d x %0d want %0d", checked, x, e.x));
            if (y !== e.y) report($sformatf("ray %0d y %0d want %0d", checked, y, e.y));
            if (z !== e.z) report($sformatf("ray %0d z %0d want %0d", checked, z, e.z));
        endtask
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic signed [COORD_W-1:0] s_point_x;
    logic signed [COORD_W-1:0] s_point_y;
    logic m_valid;
    logic m_ready;
    logic signed [COMP_W-1:0] m_dir_x;
    logic signed [COMP_W-1:0] m_dir_y;
    logic signed [COMP_W-1:0] m_dir_z;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BASIS_W-1:0] cfg_data;

    ray_scoreboard rays = new();
    int cycles = 0;
    int sent = 0;
    bit no_idle = 0;
    bit hold_out = 0;
    bit stall_done = 0;

    panoramic_ray_direction DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_point_x(s_point_x), .s_point_y(s_point_y),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_dir_x(m_dir_x), .m_dir_y(m_dir_y), .m_dir_z(m_dir_z),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("panoramic_ray_direction: mismatch");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                rays.write_reg(prd_pkg::cfg_reg_t'(cfg_index), cfg_data);
            if (s_valid && s_ready)
                rays.note(s_point_x, s_point_y);
            if (m_valid && m_ready)
                rays.check(m_dir_x, m_dir_y, m_dir_z);
        end
    end

    // result side backpressure
    initial begin
        int n;
        m_ready <= 0;
        forever begin
            if (hold_out) begin
                m_ready <= 0;
                n = 0;
                while (n < 600) begin
                    @(posedge aclk);
                    n++;
                end
                hold_out = 0;
                stall_done = 1;
            end else if (no_idle) begin
                m_ready <= 1;
                @(posedge aclk);
            end else begin
                m_ready <= 1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                n = $urandom_range(0, 19);
                n = n < 12 ? n % 3 : (n < 18 ? $urandom_range(3, 8)
                                             : $urandom_range(30, 90));
                if (n > 0) begin
                    m_ready <= 0;
                    repeat (n) @(posedge aclk);
                end
            end
        end
    end

    task automatic cfg_write(prd_pkg::cfg_reg_t idx, logic [BASIS_W-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic send_point(logic signed [31:0] px, logic signed [31:0] py);
        int g;
        s_valid <= 1;
        s_point_x <= px;
        s_point_y <= py;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
        g = $urandom_range(0, 19);
        g = no_idle ? 0 : (g < 11 ? 0 : (g < 18 ? $urandom_range(1, 4)
                                                : $urandom_range(20, 60)));
        if (g > 0) begin
            s_valid <= 0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (rays.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
    endtask

    function automatic logic [47:0] rand_basis();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic signed [31:0] rand_coord(logic [RES_W-1:0] res);
        longint unsigned half, r;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            return $urandom;
        if (pick == 3) begin
            case ($urandom_range(0, 3))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return 0;
                default: return -1;
            endcase
        end
        half = (longint'(rays.psize) * (res > 4096 ? 4096 : res)) / 2;
        if (half > 64'h7FFF_FFFF) half = 64'h7FFF_FFFF;
        r = {$urandom, $urandom};
        return 32'(longint'(r % (2 * half + 1)) - longint'(half));
    endfunction

    task automatic apply_setting(int p);
        logic [RES_W-1:0] hr, vr;
        logic [PS_W-1:0] ps;
        logic [LIM_W-1:0] hl;
        logic [VLIM_W-1:0] vl;
        logic [47:0] ru, uv, bw;
        ru = rand_basis();
        uv = rand_basis();
        bw = rand_basis();
        case (p)
            1: begin
                hr = 13'd1; vr = 13'd4096; ps = 32'd1; hl = 16'd0; vl = 15'd23040;
            end
            2: begin
                hr = 13'd4096; vr = 13'd1; ps = 32'hFFFF_FFFF; hl = 16'hFFFF; vl = 15'h7FFF;
                ru = 48'h8000_8000_8000; uv = 48'h7FFF_7FFF_7FFF; bw = 48'h8000_7FFF_8000;
            end
            3: begin
                hr = 13'd8191; vr = 13'd0; ps = 32'd65536; hl = 16'd46080; vl = 15'd0;
            end
            4: begin
                hr = 13'd0; vr = 13'd8191; ps = 32'd0; hl = 16'd1; vl = 15'd1;
            end
            default: begin
                hr = RES_W'($urandom_range(1, 4096));
                vr = RES_W'($urandom_range(1, 4096));
                ps = PS_W'($urandom_range(1 << 12, 1 << 18));
                hl = LIM_W'($urandom_range(0, 46080));
                vl = VLIM_W'($urandom_range(0, 23040));
            end
        endcase
        cfg_write(prd_pkg::REG_HRES, 48'(hr));
        cfg_write(prd_pkg::REG_VRES, 48'(vr));
        cfg_write(prd_pkg::REG_PSIZE, 48'(ps));
        cfg_write(prd_pkg::REG_HLIM, 48'(hl));
        cfg_write(prd_pkg::REG_VLIM, 48'(vl));
        cfg_write(prd_pkg::REG_RIGHT, ru);
        cfg_write(prd_pkg::REG_UP, uv);
        cfg_write(prd_pkg::REG_BACK, bw);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    initial begin
        aresetn <= 0;
        s_valid <= 0;
        s_point_x <= 0;
        s_point_y <= 0;
        cfg_valid <= 0;
        cfg_index <= prd_pkg::REG_HRES;
        cfg_data <= 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // defaults: 640 x 480 plane, the whole of it spans the full field
        send_point(0, 0);
        send_point(320 << 16, 0);
        send_point(-(320 << 16), 0);
        send_point(160 << 16, 0);
        send_point(-(160 << 16), 0);
        send_point(0, 240 << 16);
        send_point(0, -(240 << 16));
        send_point(0, 120 << 16);
        send_point(80 << 16, 60 << 16);
        send_point(-(240 << 16), -(180 << 16));
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_point(32'sh8000_0000, 32'sh8000_0000);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_point(1, -1);
        send_point(-1, 1);
        send_point(640 << 16, 480 << 16);
        send_point(1000 << 16, -(1000 << 16));
        send_point(32'sh5555_5555, 32'shAAAA_AAAA);
        drain();

        for (int p = 1; p <= 7; p++) begin
            apply_setting(p);
            no_idle = (p == 6);
            for (int i = 0; i < 200; i++) begin
                if (p == 7 && i == 20)
                    hold_out = 1;
                send_point(rand_coord(rays.hres), rand_coord(rays.vres));
            end
            no_idle = 0;
            drain();
        end

        $display("sent %0d points over 8 register settings, %0d rays checked%s",
                 sent, rays.checked, stall_done ? ", with a long output stall" : "");
        if (rays.errors == 0 && rays.pending.size() == 0)
            $display("panoramic_ray_direction: match");
        else
            $display("panoramic_ray_direction: mismatch");
        $finish;
    end
endmodule

[panoramic_ray_direction.f]
rtl/core/prd_pkg.sv
rtl/core/prd_div_cell.sv
rtl/core/prd_cordic_cell.sv
rtl/core/prd_lane.sv
rtl/core/prd_combine.sv
rtl/core/panoramic_ray_direction.sv
sim/tb.sv
